### design/i2c_master_byte_sequencer_defines.svh
// assertion macros used by the i2c master byte sequencer port checker
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define I2CM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/i2cm_pkg.sv
// types and constants shared by the i2c master byte sequencer
package i2cm_pkg;

  localparam int TPU_W   = 10;
  localparam int LIMIT_W = 8;
  localparam int WAIT_W  = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

  localparam logic [TPU_W-1:0]   TPU_RESET   = 10'd240;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd250;

  // command codes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_item_t;

endpackage

### design/i2cm_ifs.sv
// valid/ready channel interfaces for the input and result words
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] mode;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, output cmd_valid, output mode, output tx_byte,
                  output send_ack, output sda_in, input ready);
  modport sink   (input valid, input cmd_valid, input mode, input tx_byte,
                  input send_ack, input sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output rx_byte, output ack_failed, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input rx_byte, input ack_failed, output ready);
endinterface

### design/i2cm_core.sv
// bus sequencer state and the one-tick step of the i2c master
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  in_item_t           item,
  input  logic [TPU_W-1:0]   ticks_per_us,
  input  logic [LIMIT_W-1:0] ack_poll_limit,
  output out_item_t          res
);

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_ST1   = 5'd1;
  localparam logic [4:0] PH_ST2   = 5'd2;
  localparam logic [4:0] PH_FIN   = 5'd3;
  localparam logic [4:0] PH_SP1   = 5'd4;
  localparam logic [4:0] PH_SP2   = 5'd5;
  localparam logic [4:0] PH_WDATA = 5'd6;
  localparam logic [4:0] PH_WHIGH = 5'd7;
  localparam logic [4:0] PH_WLOW  = 5'd8;
  localparam logic [4:0] PH_WEND  = 5'd9;
  localparam logic [4:0] PH_AK0   = 5'd10;
  localparam logic [4:0] PH_AK1   = 5'd11;
  localparam logic [4:0] PH_AK2   = 5'd12;
  localparam logic [4:0] PH_POLL  = 5'd13;
  localparam logic [4:0] PH_RLOW  = 5'd14;
  localparam logic [4:0] PH_RHIGH = 5'd15;
  localparam logic [4:0] PH_RA0   = 5'd16;
  localparam logic [4:0] PH_RA1   = 5'd17;
  localparam logic [4:0] PH_RA2   = 5'd18;

  logic [4:0]        phase_r, phase_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        poll_r, poll_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              ackc_r, ackc_nxt;
  logic [7:0]        rx_r, rx_nxt;
  logic              fail_r, fail_nxt;

  logic [WAIT_W-1:0] wait_1us, wait_2us, wait_4us, wait_dec;
  logic [3:0]        bit_inc;
  logic              act, done;

  // 1, 2 and 4 us waits, ticks_per_us shifted into the counter width with no bits lost
  assign wait_1us = {2'b00, ticks_per_us};
  assign wait_2us = {1'b0, ticks_per_us, 1'b0};
  assign wait_4us = {ticks_per_us, 2'b00};
  assign wait_dec = wait_r - 1'b1;
  assign bit_inc  = bit_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ackc_nxt  = ackc_r;
    rx_nxt    = rx_r;
    fail_nxt  = fail_r;
    done      = 1'b0;
    act       = 1'b1;

    if (phase_r == PH_IDLE) begin
      act = 1'b0;
      if (item.cmd_valid) begin
        ackc_nxt = item.send_ack;
        fail_nxt = 1'b0;
        unique case (item.mode)
          MODE_START: begin
            sda_nxt = 1'b1; scl_nxt = 1'b1; wait_nxt = wait_4us; phase_nxt = PH_ST1;
          end
          MODE_STOP: begin
            sda_nxt = 1'b0; wait_nxt = wait_4us; phase_nxt = PH_SP1;
          end
          MODE_WRITE: begin
            bit_nxt = '0; shift_nxt = item.tx_byte;
            scl_nxt = 1'b0; wait_nxt = wait_4us; phase_nxt = PH_WDATA;
          end
          MODE_READ: begin
            bit_nxt = '0; shift_nxt = '0;
            scl_nxt = 1'b0; sda_nxt = 1'b1; wait_nxt = wait_2us; phase_nxt = PH_RHIGH;
          end
        endcase
      end
    end else if (wait_r != '0) begin
      wait_nxt = wait_dec;
      if (wait_dec != '0) act = 1'b0;
    end

    if (act) begin
      unique case (phase_r)
        PH_ST1:  begin sda_nxt = 1'b0; wait_nxt = wait_4us; phase_nxt = PH_ST2; end
        PH_ST2:  begin scl_nxt = 1'b0; wait_nxt = wait_4us; phase_nxt = PH_FIN; end
        PH_SP1:  begin scl_nxt = 1'b1; wait_nxt = wait_4us; phase_nxt = PH_SP2; end
        PH_SP2:  begin sda_nxt = 1'b1; wait_nxt = wait_4us; phase_nxt = PH_FIN; end
        PH_WDATA: begin
          sda_nxt = shift_r[7]; wait_nxt = wait_4us; phase_nxt = PH_WHIGH;
        end
        PH_WHIGH: begin
          scl_nxt   = 1'b1;
          wait_nxt  = wait_4us;
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_inc;
          phase_nxt = (bit_inc >= 4'd8) ? PH_WEND : PH_WLOW;
        end
        PH_WLOW: begin scl_nxt = 1'b0; wait_nxt = wait_4us; phase_nxt = PH_WDATA; end
        PH_WEND: begin scl_nxt = 1'b0; wait_nxt = wait_2us; phase_nxt = PH_AK0; end
        PH_AK0:  begin scl_nxt = 1'b0; wait_nxt = wait_4us; phase_nxt = PH_AK1; end
        PH_AK1:  begin sda_nxt = 1'b1; wait_nxt = wait_4us; phase_nxt = PH_AK2; end
        PH_AK2: begin
          scl_nxt = 1'b1; wait_nxt = wait_4us; poll_nxt = '0; phase_nxt = PH_POLL;
        end
        PH_POLL: begin
          if (!item.sda_in) begin
            scl_nxt = 1'b0; wait_nxt = wait_4us; phase_nxt = PH_FIN;
          end else if (poll_r >= ack_poll_limit) begin
            // no ack in time: flag it and run the stop sequence
            fail_nxt = 1'b1;
            sda_nxt = 1'b0; wait_nxt = wait_4us; phase_nxt = PH_SP1;
          end else begin
            poll_nxt = poll_r + 1'b1;
          end
        end
        PH_RLOW: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; wait_nxt = wait_2us; phase_nxt = PH_RHIGH;
        end
        PH_RHIGH: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], item.sda_in};
          bit_nxt   = bit_inc;
          wait_nxt  = wait_1us;
          phase_nxt = (bit_inc >= 4'd8) ? PH_RA0 : PH_RLOW;
        end
        PH_RA0: begin
          scl_nxt = 1'b0; sda_nxt = !ackc_r; wait_nxt = wait_2us; phase_nxt = PH_RA1;
        end
        PH_RA1:  begin scl_nxt = 1'b1; wait_nxt = wait_2us; phase_nxt = PH_RA2; end
        PH_RA2: begin
          scl_nxt = 1'b0; rx_nxt = shift_r; done = 1'b1; phase_nxt = PH_IDLE;
        end
        PH_FIN:  begin done = 1'b1; phase_nxt = PH_IDLE; end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      poll_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ackc_r  <= 1'b0;
      rx_r    <= '0;
      fail_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      poll_r  <= poll_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ackc_r  <= ackc_nxt;
      rx_r    <= rx_nxt;
      fail_r  <= fail_nxt;
    end
  end

  always_comb begin
    res.scl_out    = scl_nxt;
    res.sda_out    = sda_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_nxt;
    res.ack_failed = fail_nxt;
  end

endmodule

### design/i2c_master_byte_sequencer.sv
// top level of the i2c master byte sequencer: handshake stages and config registers
//
//  channel  dir  handshake          word
//  in_ch    in   valid/ready        cmd_valid, mode, tx_byte, send_ack, sda_in (one bus tick)
//  out_ch   out  valid/ready        scl_out, sda_out, busy_res, done_res, rx_byte, ack_failed
//  cfg_*    in   cfg_we, no ready   cfg_index selects ticks_per_us or ack_poll_limit
//
// one word in, one word out; a word can be taken every cycle while out_ch is ready
// a word passes the input register, then the step logic into the result register
// the step logic is one pass over the sequencer state, set by the wait counter compare
// a stalled output holds its word; the input register still takes one more word
// reset (synchronous, rst_n low) idles the bus with scl and sda released
module i2c_master_byte_sequencer
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  i2cm_in_if.sink               in_ch,
  i2cm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [TPU_W-1:0]   tpu_r;
  logic [LIMIT_W-1:0] limit_r;

  // input stage
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // result stage
  logic      out_valid_r;
  out_item_t out_item_r;

  out_item_t step_res;
  logic      advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r   <= TPU_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_US:   tpu_r   <= cfg_data[TPU_W-1:0];
        CFG_ACK_POLL_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // the held word steps the sequencer when the result register is free or draining
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.cmd_valid <= in_ch.cmd_valid;
      s1_item_r.mode      <= in_ch.mode;
      s1_item_r.tx_byte   <= in_ch.tx_byte;
      s1_item_r.send_ack  <= in_ch.send_ack;
      s1_item_r.sda_in    <= in_ch.sda_in;
    end
  end

  i2cm_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .item           (s1_item_r),
    .ticks_per_us   (tpu_r),
    .ack_poll_limit (limit_r),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= step_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_out    = out_item_r.scl_out;
  assign out_ch.sda_out    = out_item_r.sda_out;
  assign out_ch.busy_res   = out_item_r.busy_res;
  assign out_ch.done_res   = out_item_r.done_res;
  assign out_ch.rx_byte    = out_item_r.rx_byte;
  assign out_ch.ack_failed = out_item_r.ack_failed;

endmodule

### design/i2cm_checker.sv
// port-level checks for the i2c master byte sequencer and their bind
`include "i2c_master_byte_sequencer_defines.svh"

module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_out,
  input logic       sda_out,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] rx_byte,
  input logic       ack_failed
);

  logic in_seen;
  assign in_seen = in_valid;

  // a finished command leaves the block idle
  `I2CM_ASSERT_IMP(a_done_idle, out_valid && done_res, !busy_res && in_seen == in_seen, "done word still busy")

  // a timed-out write ends with the stop sequence done, both lines released
  `I2CM_ASSERT_IMP(a_fail_released, out_valid && done_res && ack_failed, scl_out && sda_out, "ack timeout without released bus")

  // an empty result register never holds off the input
  `I2CM_ASSERT_IMP(a_no_false_stall, !out_valid, in_ready, "input stalled with empty output")

  // a stalled result word holds
  `I2CM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rx_byte) && $stable(done_res), "stalled result word changed")

endmodule

bind i2c_master_byte_sequencer i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .scl_out    (out_ch.scl_out),
  .sda_out    (out_ch.sda_out),
  .busy_res   (out_ch.busy_res),
  .done_res   (out_ch.done_res),
  .rx_byte    (out_ch.rx_byte),
  .ack_failed (out_ch.ack_failed)
);

### test/i2cm_seq_checker.sv
`timescale 1ns / 100ps
// checker for the i2c master byte sequencer: predicts each result word and compares it
module i2cm_seq_checker
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  i2cm_in_if                    in_mon,
  i2cm_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    words_due,
  output logic                  bus_idle
);

  typedef enum logic [4:0] {
    SEQ_IDLE, START_SDA_LOW, START_SCL_LOW, CMD_DONE, STOP_SCL_HIGH, STOP_SDA_HIGH,
    WR_SET_BIT, WR_SCL_HIGH, WR_SCL_LOW, WR_BITS_DONE, ACK_SCL_LOW, ACK_RELEASE,
    ACK_SCL_HIGH, ACK_POLL, RD_SCL_LOW, RD_SAMPLE, RD_ACK_DRIVE, RD_ACK_HIGH, RD_ACK_END
  } seq_step_t;

  seq_step_t          bus_step;
  logic [TPU_W-1:0]   tick_scale;
  logic [LIMIT_W-1:0] poll_limit;
  logic [WAIT_W-1:0]  wait_left;
  logic [3:0]         bits_done;
  logic [7:0]         shreg;
  logic [7:0]         high_polls;
  logic               scl_drv;
  logic               sda_drv;
  logic               ack_sel;
  logic               ack_timeout;
  logic [7:0]         last_rx;
  out_item_t          pin_words_due[$];

  function automatic void load_wait(int us);
    wait_left = WAIT_W'(us * tick_scale);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // one bus tick of the sequencer
  task automatic bus_tick(input in_item_t w, output out_item_t r);
    logic fire;
    logic done;
    fire = 1'b1;
    done = 1'b0;
    if (bus_step == SEQ_IDLE) begin
      fire = 1'b0;
      if (w.cmd_valid) begin
        ack_sel = w.send_ack;
        ack_timeout = 1'b0;
        case (w.mode)
          MODE_START: begin
            sda_drv = 1'b1; scl_drv = 1'b1; load_wait(4); bus_step = START_SDA_LOW;
          end
          MODE_STOP: begin
            sda_drv = 1'b0; load_wait(4); bus_step = STOP_SCL_HIGH;
          end
          MODE_WRITE: begin
            bits_done = '0; shreg = w.tx_byte; scl_drv = 1'b0; load_wait(4);
            bus_step = WR_SET_BIT;
          end
          MODE_READ: begin
            bits_done = '0; shreg = '0; scl_drv = 1'b0; sda_drv = 1'b1; load_wait(2);
            bus_step = RD_SAMPLE;
          end
        endcase
      end
    end else if (wait_left != '0) begin
      wait_left = wait_left - 1'b1;
      if (wait_left != '0) fire = 1'b0;
    end

    if (fire) begin
      case (bus_step)
        START_SDA_LOW: begin sda_drv = 1'b0; load_wait(4); bus_step = START_SCL_LOW; end
        START_SCL_LOW: begin scl_drv = 1'b0; load_wait(4); bus_step = CMD_DONE; end
        STOP_SCL_HIGH: begin scl_drv = 1'b1; load_wait(4); bus_step = STOP_SDA_HIGH; end
        STOP_SDA_HIGH: begin sda_drv = 1'b1; load_wait(4); bus_step = CMD_DONE; end
        WR_SET_BIT: begin sda_drv = shreg[7]; load_wait(4); bus_step = WR_SCL_HIGH; end
        WR_SCL_HIGH: begin
          scl_drv = 1'b1; load_wait(4);
          shreg = {shreg[6:0], 1'b0};
          bits_done = bits_done + 1'b1;
          bus_step = (bits_done >= 4'd8) ? WR_BITS_DONE : WR_SCL_LOW;
        end
        WR_SCL_LOW: begin scl_drv = 1'b0; load_wait(4); bus_step = WR_SET_BIT; end
        WR_BITS_DONE: begin scl_drv = 1'b0; load_wait(2); bus_step = ACK_SCL_LOW; end
        ACK_SCL_LOW: begin scl_drv = 1'b0; load_wait(4); bus_step = ACK_RELEASE; end
        ACK_RELEASE: begin sda_drv = 1'b1; load_wait(4); bus_step = ACK_SCL_HIGH; end
        ACK_SCL_HIGH: begin
          scl_drv = 1'b1; load_wait(4); high_polls = '0; bus_step = ACK_POLL;
        end
        ACK_POLL: begin
          if (!w.sda_in) begin
            scl_drv = 1'b0; load_wait(4); bus_step = CMD_DONE;
          end else if (high_polls >= poll_limit) begin
            // no ack in time: force a stop and flag it
            ack_timeout = 1'b1; sda_drv = 1'b0; load_wait(4); bus_step = STOP_SCL_HIGH;
          end else begin
            high_polls = high_polls + 1'b1;
          end
        end
        RD_SCL_LOW: begin
          scl_drv = 1'b0; sda_drv = 1'b1; load_wait(2); bus_step = RD_SAMPLE;
        end
        RD_SAMPLE: begin
          scl_drv = 1'b1;
          shreg = {shreg[6:0], w.sda_in};
          bits_done = bits_done + 1'b1;
          load_wait(1);
          bus_step = (bits_done >= 4'd8) ? RD_ACK_DRIVE : RD_SCL_LOW;
        end
        RD_ACK_DRIVE: begin
          scl_drv = 1'b0; sda_drv = !ack_sel; load_wait(2); bus_step = RD_ACK_HIGH;
        end
        RD_ACK_HIGH: begin scl_drv = 1'b1; load_wait(2); bus_step = RD_ACK_END; end
        RD_ACK_END: begin
          scl_drv = 1'b0; last_rx = shreg; done = 1'b1; bus_step = SEQ_IDLE;
        end
        CMD_DONE: begin done = 1'b1; bus_step = SEQ_IDLE; end
        default: bus_step = SEQ_IDLE;
      endcase
    end

    r.scl_out    = scl_drv;
    r.sda_out    = sda_drv;
    r.busy_res   = (bus_step != SEQ_IDLE);
    r.done_res   = done;
    r.rx_byte    = last_rx;
    r.ack_failed = ack_timeout;
  endtask

  always @(posedge clk) begin
    in_item_t  w;
    out_item_t got;
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      bus_step    = SEQ_IDLE;
      tick_scale  = TPU_RESET;
      poll_limit  = LIMIT_RESET;
      wait_left   = '0;
      bits_done   = '0;
      shreg       = '0;
      high_polls  = '0;
      scl_drv     = 1'b1;
      sda_drv     = 1'b1;
      ack_sel     = 1'b0;
      ack_timeout = 1'b0;
      last_rx     = '0;
      mismatches  = 0;
      pin_words_due.delete();
    end else begin
      // results first, so a word cannot match an expectation made on the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.scl_out    = out_mon.scl_out;
        got.sda_out    = out_mon.sda_out;
        got.busy_res   = out_mon.busy_res;
        got.done_res   = out_mon.done_res;
        got.rx_byte    = out_mon.rx_byte;
        got.ack_failed = out_mon.ack_failed;
        if (pin_words_due.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pin_words_due.pop_front();
          if (got.scl_out !== want.scl_out)
            report_mismatch($sformatf("scl_out %b want %b", got.scl_out, want.scl_out));
          if (got.sda_out !== want.sda_out)
            report_mismatch($sformatf("sda_out %b want %b", got.sda_out, want.sda_out));
          if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b want %b", got.busy_res, want.busy_res));
          if (got.done_res !== want.done_res)
            report_mismatch($sformatf("done_res %b want %b", got.done_res, want.done_res));
          if (got.rx_byte !== want.rx_byte)
            report_mismatch($sformatf("rx_byte %h want %h", got.rx_byte, want.rx_byte));
          if (got.ack_failed !== want.ack_failed)
            report_mismatch($sformatf("ack_failed %b want %b", got.ack_failed,
                                      want.ack_failed));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICKS_PER_US:   tick_scale = cfg_data[TPU_W-1:0];
          CFG_ACK_POLL_LIMIT: poll_limit = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        w.cmd_valid = in_mon.cmd_valid;
        w.mode      = in_mon.mode;
        w.tx_byte   = in_mon.tx_byte;
        w.send_ack  = in_mon.send_ack;
        w.sda_in    = in_mon.sda_in;
        bus_tick(w, fresh);
        pin_words_due.push_back(fresh);
      end
    end
    words_due = pin_words_due.size();
    bus_idle  = (bus_step == SEQ_IDLE);
  end

endmodule

### test/tb_i2c_master_byte_sequencer.sv
`timescale 1ns / 100ps
// testbench top for the i2c master byte sequencer: stimulus, receiver stalls and verdict
module tb_i2c_master_byte_sequencer;
  import i2cm_pkg::*;

  // cycles with no word moving on either channel before the run is called hung
  localparam int STALL_LIMIT     = 5000;
  // length of the one long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 64;
  // rough size of the random part, in bus ticks
  localparam int RANDOM_TICKS    = 200;

  // how the fake slave drives sda while a command runs
  typedef enum int {SDA_HIGH, SDA_LOW, SDA_COIN, SDA_LATE_LOW} sda_style_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    words_due;
  logic                  bus_idle;
  logic                  calm;       // no idling on either side while set
  logic                  hold_req;   // asks the receiver for one long hold-off
  int                    idle_cycles;
  int                    sent_ticks;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();

  i2c_master_byte_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cm_seq_checker pin_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .words_due  (words_due),
    .bus_idle   (bus_idle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random ready, one long hold-off on request, none at all while calm
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int i = 0; i < HOLD_OFF_CYCLES; i++) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // watchdog: ends the run when nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one tick word, with a random gap in front unless calm
  // called and returning at a falling edge
  task automatic push_tick(input in_item_t w);
    if (!calm) begin
      while ($urandom_range(99) < 16) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd_valid <= w.cmd_valid;
    in_ch.mode      <= w.mode;
    in_ch.tx_byte   <= w.tx_byte;
    in_ch.send_ack  <= w.send_ack;
    in_ch.sda_in    <= w.sda_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_ticks++;
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (words_due != 0);
  endtask

  // both registers are written with the bus idle and nothing in flight
  task automatic set_regs(input logic [TPU_W-1:0] tpu, input logic [LIMIT_W-1:0] limit);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TICKS_PER_US;
    cfg_data  <= tpu;
    @(negedge clk);
    cfg_index <= CFG_ACK_POLL_LIMIT;
    cfg_data  <= limit;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // issue one command, then tick until the sequencer goes idle again
  task automatic run_cmd(input logic [1:0] mode, input logic [7:0] tx, input logic ack,
                         input sda_style_t style);
    in_item_t w;
    w.cmd_valid = 1'b1;
    w.mode      = mode;
    w.tx_byte   = tx;
    w.send_ack  = ack;
    w.sda_in    = 1'($urandom_range(1));
    push_tick(w);
    while (!bus_idle) begin
      // stray commands while busy must be ignored
      w.cmd_valid = ($urandom_range(7) == 0);
      w.mode      = 2'($urandom_range(3));
      w.tx_byte   = 8'($urandom_range(255));
      w.send_ack  = 1'($urandom_range(1));
      case (style)
        SDA_HIGH:     w.sda_in = 1'b1;
        SDA_LOW:      w.sda_in = 1'b0;
        SDA_COIN:     w.sda_in = 1'($urandom_range(1));
        SDA_LATE_LOW: w.sda_in = ($urandom_range(63) != 0);
      endcase
      push_tick(w);
    end
    // up to two quiet ticks between commands
    repeat ($urandom_range(2)) begin
      w.cmd_valid = 1'b0;
      w.sda_in    = 1'($urandom_range(1));
      push_tick(w);
    end
  endtask

  // mostly a prompt ack, sometimes late, noisy or missing
  function automatic sda_style_t pick_ack_style();
    case ($urandom_range(9))
      0:       return SDA_HIGH;
      1:       return SDA_COIN;
      2:       return SDA_LATE_LOW;
      default: return SDA_LOW;
    endcase
  endfunction

  // start, address, one to three data bytes, usually a stop; now and then a stray command
  task automatic run_transaction();
    int         n;
    logic       rd;
    logic [7:0] addr;
    rd   = 1'($urandom_range(1));
    addr = {7'($urandom_range(127)), rd};
    n    = $urandom_range(1, 3);
    if ($urandom_range(4) == 0)
      run_cmd(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
              sda_style_t'($urandom_range(3)));
    run_cmd(MODE_START, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_COIN);
    run_cmd(MODE_WRITE, addr, 1'($urandom_range(1)), pick_ack_style());
    for (int i = 0; i < n; i++) begin
      if (rd)
        run_cmd(MODE_READ, 8'($urandom_range(255)), i != n - 1, SDA_COIN);
      else
        run_cmd(MODE_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                pick_ack_style());
    end
    // broken sequences: sometimes the stop is left out
    if ($urandom_range(5) != 0)
      run_cmd(MODE_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_COIN);
  endtask

  initial begin
    int                 phase_cnt;
    int                 random_start;
    logic [TPU_W-1:0]   tpu;
    logic [LIMIT_W-1:0] limit;
    rst_n           = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    sent_ticks      = 0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_TICKS_PER_US;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd_valid = 1'b0;
    in_ch.mode      = MODE_START;
    in_ch.tx_byte   = '0;
    in_ch.send_ack  = 1'b0;
    in_ch.sda_in    = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero ticks per microsecond: a step on every tick; poll limit zero
    set_regs(10'd0, 8'd0);
    run_cmd(MODE_START, 8'hFF, 1'b1, SDA_COIN);
    run_cmd(MODE_WRITE, 8'hFF, 1'b1, SDA_HIGH);     // fails on the first high sample
    run_cmd(MODE_WRITE, 8'h00, 1'b0, SDA_LOW);      // prompt ack
    run_cmd(MODE_WRITE, 8'hA5, 1'b0, SDA_LATE_LOW);
    run_cmd(MODE_READ, 8'h00, 1'b1, SDA_HIGH);      // all ones, then ack
    run_cmd(MODE_READ, 8'hFF, 1'b0, SDA_LOW);       // all zeros, then nack
    run_cmd(MODE_STOP, 8'h00, 1'b0, SDA_COIN);

    // largest poll limit: 256 high samples before the forced stop
    set_regs(10'd0, 8'd255);
    run_cmd(MODE_START, 8'h3C, 1'b0, SDA_COIN);
    run_cmd(MODE_WRITE, 8'h5A, 1'b1, SDA_HIGH);
    run_cmd(MODE_WRITE, 8'hC3, 1'b0, SDA_LATE_LOW);
    run_cmd(MODE_READ, 8'h3C, 1'b1, SDA_COIN);
    run_cmd(MODE_STOP, 8'hC3, 1'b1, SDA_COIN);

    // random phases, each with its own timing and poll limit
    random_start = sent_ticks;
    phase_cnt    = 0;
    while (sent_ticks - random_start < RANDOM_TICKS || phase_cnt < 4) begin
      tpu   = ($urandom_range(3) == 0) ? 10'($urandom_range(1, 2)) : 10'd0;
      limit = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4));
      set_regs(tpu, limit);
      // second phase runs with no idling at all
      calm = (phase_cnt == 1);
      // first phase: receiver holds off while words keep coming, so the input stalls
      if (phase_cnt == 0) hold_req = 1'b1;
      for (int t = 0; t < 2; t++) begin
        run_transaction();
        // third phase: sender pauses until the pipeline is empty
        if (phase_cnt == 2 && t == 0) drain_results();
      end
      phase_cnt++;
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
